FILE: rtl/iir_df2_pkg.sv
// Shared types and constants for the direct form II biquad filter.
// Used by iir_df2_ctrl, iir_df2_datapath and iir_direct_form_two_filter.
`default_nettype none

package iir_df2_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int STATE_W   = 20;
    localparam int PROD_W    = COEF_W + STATE_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int FRAC_BITS = 14;
    localparam int SCALED_W  = ACC_W - FRAC_BITS;
    localparam int NUM_COEF  = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

    // Coefficient codes, also the configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic [1:0] {
        W_SEL_W0,
        W_SEL_W1,
        W_SEL_W2
    } w_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_SAT_W,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_ACC_Y,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic      load_x;
        logic      mul_en;
        coef_sel_t coef_sel;
        w_sel_t    w_sel;
        acc_op_t   acc_op;
        logic      sat_w;
        logic      emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/iir_df2_ctrl.sv
// Sequencer for the biquad: steps the shared multiply-accumulate through
// the feedback and feedforward products. Depends on iir_df2_pkg.
`default_nettype none

module iir_df2_ctrl
    import iir_df2_pkg::*;
#(
    parameter int ORDER = 2
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.coef_sel = COEF_B0;
        cmd.w_sel    = W_SEL_W1;
        cmd.acc_op   = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_x = 1'b1;
                    state_next = ST_MUL_A1;
                end
            end
            ST_MUL_A1: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_A1;
                cmd.w_sel    = W_SEL_W1;
                state_next   = (ORDER >= 2) ? ST_MUL_A2 : ST_SAT_W;
            end
            ST_MUL_A2: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_A2;
                cmd.w_sel    = W_SEL_W2;
                cmd.acc_op   = ACC_SUB;
                state_next   = ST_SAT_W;
            end
            ST_SAT_W: begin
                // subtract the last feedback product and clamp into w0
                cmd.acc_op = ACC_SUB;
                cmd.sat_w  = 1'b1;
                state_next = ST_MUL_B0;
            end
            ST_MUL_B0: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_B0;
                cmd.w_sel    = W_SEL_W0;
                state_next   = ST_MUL_B1;
            end
            ST_MUL_B1: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_B1;
                cmd.w_sel    = W_SEL_W1;
                cmd.acc_op   = ACC_ADD;
                state_next   = (ORDER >= 2) ? ST_MUL_B2 : ST_ACC_Y;
            end
            ST_MUL_B2: begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = COEF_B2;
                cmd.w_sel    = W_SEL_W2;
                cmd.acc_op   = ACC_ADD;
                state_next   = ST_ACC_Y;
            end
            ST_ACC_Y: begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold here until the output register can take the result
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/iir_df2_datapath.sv
// Datapath for the biquad: coefficient registers, delay line, one shared
// multiplier with accumulator, saturation and the output register.
// Depends on iir_df2_pkg.
`default_nettype none

module iir_df2_datapath
    import iir_df2_pkg::*;
#(
    parameter int ORDER = 2
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wen,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [COEF_W-1:0]    cfg_wdata,
    input  wire [SAMPLE_W-1:0]  s_tdata,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output logic                m_tuser,
    input  dp_cmd_t             cmd,
    output dp_status_t          status
);

    localparam logic signed [SCALED_W-1:0] W_MAX = SCALED_W'(2 ** (STATE_W - 1) - 1);
    localparam logic signed [SCALED_W-1:0] W_MIN = SCALED_W'(-(2 ** (STATE_W - 1)));
    localparam logic signed [SCALED_W-1:0] Y_MAX = SCALED_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [SCALED_W-1:0] Y_MIN = SCALED_W'(-(2 ** (SAMPLE_W - 1)));

    logic signed [COEF_W-1:0]   coef_reg [NUM_COEF];
    logic signed [STATE_W-1:0]  w0_reg, w1_reg, w2_q;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next, acc_sum, prod_ext;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [COEF_W-1:0]   coef_op;
    logic signed [STATE_W-1:0]  w_op, w_sat;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       w_clip, y_clip, clip_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_clip_reg;

    assign x = s_tdata;

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[COEF_B0] <= COEF_W'(2 ** FRAC_BITS);
            coef_reg[COEF_B1] <= '0;
            coef_reg[COEF_B2] <= '0;
            coef_reg[COEF_A1] <= '0;
            coef_reg[COEF_A2] <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                COEF_B0: coef_reg[COEF_B0] <= cfg_wdata;
                COEF_B1: coef_reg[COEF_B1] <= cfg_wdata;
                COEF_B2: coef_reg[COEF_B2] <= cfg_wdata;
                COEF_A1: coef_reg[COEF_A1] <= cfg_wdata;
                COEF_A2: coef_reg[COEF_A2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Operand select and multiplier
    assign coef_op = coef_reg[cmd.coef_sel];

    always_comb begin
        case (cmd.w_sel)
            W_SEL_W0: w_op = w0_reg;
            W_SEL_W2: w_op = w2_q;
            default:  w_op = w1_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= coef_op * w_op;
        end
    end

    // Accumulator works on the product registered in the previous step
    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        case (cmd.acc_op)
            ACC_ADD: acc_sum = acc_reg + prod_ext;
            ACC_SUB: acc_sum = acc_reg - prod_ext;
            default: acc_sum = acc_reg;
        endcase
    end

    assign scaled = acc_sum[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (cmd.load_x) begin
            acc_next = (ACC_W'(x) <<< FRAC_BITS) + ROUND_HALF;
        end else if (cmd.sat_w) begin
            acc_next = ROUND_HALF;
        end else begin
            acc_next = acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Saturation of the state value and of the output
    always_comb begin
        w_clip = 1'b0;
        if (scaled > W_MAX) begin
            w_sat  = W_MAX[STATE_W-1:0];
            w_clip = 1'b1;
        end else if (scaled < W_MIN) begin
            w_sat  = W_MIN[STATE_W-1:0];
            w_clip = 1'b1;
        end else begin
            w_sat = scaled[STATE_W-1:0];
        end
    end

    always_comb begin
        y_clip = 1'b0;
        if (scaled > Y_MAX) begin
            y_sat  = Y_MAX[SAMPLE_W-1:0];
            y_clip = 1'b1;
        end else if (scaled < Y_MIN) begin
            y_sat  = Y_MIN[SAMPLE_W-1:0];
            y_clip = 1'b1;
        end else begin
            y_sat = scaled[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sat_w) begin
            w0_reg   <= w_sat;
            clip_reg <= w_clip;
        end
    end

    // Delay line: advance once the result is emitted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_reg <= '0;
        end else if (cmd.emit) begin
            w1_reg <= w0_reg;
        end
    end

    generate
        if (ORDER >= 2) begin : g_second_tap
            logic signed [STATE_W-1:0] w2_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    w2_reg <= '0;
                end else if (cmd.emit) begin
                    w2_reg <= w1_reg;
                end
            end

            assign w2_q = w2_reg;
        end else begin : g_no_second_tap
            assign w2_q = '0;
        end
    endgenerate

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= y_sat;
            out_clip_reg <= clip_reg | y_clip;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_clip_reg;

endmodule

`default_nettype wire

FILE: rtl/iir_direct_form_two_filter.sv
// Second-order direct form II IIR filter (biquad), fixed point.
// Top level: iir_df2_ctrl sequencer plus iir_df2_datapath. Depends on iir_df2_pkg.
//
// Usage:
//   Input samples (signed Q15) arrive on the s_ stream; one filtered sample
//   (signed Q15, saturated) leaves on the m_ stream per input, with a clip
//   flag on m_tuser set when the state value or the output saturated.
//   Coefficients b0, b1, b2, a1, a2 (signed Q3.14, a0 taken as 1) are
//   written through cfg_wen/cfg_index/cfg_wdata while the filter is idle;
//   indexes beyond a2 are ignored.
//   One multiplier is shared by all products, at most one product per cycle.
//   s_tready is high only while the sequencer is idle. After a transfer the
//   sequencer steps through ST_MUL_A1, ST_MUL_A2 (ORDER = 2 only), ST_SAT_W,
//   ST_MUL_B0, ST_MUL_B1, ST_MUL_B2 (ORDER = 2 only), ST_ACC_Y and ST_EMIT;
//   the result shows on m_tvalid the cycle after ST_EMIT, and a new sample
//   can be taken on that same cycle, but not before the last one is emitted.
//   The result waits in an output register; if it has not been taken when
//   the next result is ready, the sequencer holds until it is.
//   Reset clears the delay line and loads b0 = 1.0 with all other
//   coefficients zero, so the filter passes samples through.
`default_nettype none

module iir_direct_form_two_filter
    import iir_df2_pkg::*;
#(
    parameter int ORDER = 2
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // configuration write port
    input  wire                 cfg_wen,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [COEF_W-1:0]    cfg_wdata,
    // input stream
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
    // result stream
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
    output logic                m_tuser    // [0] clipped
);

    dp_cmd_t    cmd;
    dp_status_t status;

    iir_df2_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iir_df2_datapath #(
        .ORDER (ORDER)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
